// ----- rtl/lvn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvn_pkg
// Constants, hash and blend helpers shared by the layered value noise block.
// ----------------------------------------------------------------------------
package lvn_pkg;

  localparam int unsigned MaxOctavesDefault = 8;

  localparam logic [1:0] CFG_OCTAVES = 2'd0;
  localparam logic [1:0] CFG_FREQ    = 2'd1;
  localparam logic [1:0] CFG_SEED    = 2'd2;

  localparam logic [3:0]  OctavesReset = 4'd4;
  localparam logic [23:0] FreqReset    = 24'd65536;
  localparam logic [31:0] SeedReset    = 32'd0;

  localparam logic [31:0] HashX    = 32'd374761393;
  localparam logic [31:0] HashZ    = 32'd668265263;
  localparam logic [31:0] HashSeed = 32'd1274126177;
  localparam logic [31:0] HashMul  = 32'd1103515245;
  localparam logic [17:0] SmoothK  = 18'd196608;

  typedef struct packed {
    logic valid;
  } lvn_ctl_t;

  function automatic logic [31:0] hash_mix(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0] h;
    h = a + b + c;
    return 32'((h ^ (h >> 13)) * HashMul);
  endfunction

  function automatic logic [15:0] hash_value(logic [31:0] g);
    logic [31:0] c;
    c = g ^ (g >> 16);
    return c[30:15];
  endfunction

  function automatic logic [15:0] lerp16(logic [15:0] a, logic [15:0] b, logic [16:0] s);
    logic [33:0] p;
    p = 34'(a) * 34'(17'h10000 - s) + 34'(b) * 34'(s);
    return p[31:16];
  endfunction

  // round(2^32 / (2^n - 1))
  function automatic logic [32:0] recip(logic [4:0] n);
    logic [32:0] r;
    case (n)
      5'd1:    r = 33'd4294967296;
      5'd2:    r = 33'd1431655765;
      5'd3:    r = 33'd613566757;
      5'd4:    r = 33'd286331153;
      5'd5:    r = 33'd138547332;
      5'd6:    r = 33'd68174084;
      5'd7:    r = 33'd33818640;
      5'd8:    r = 33'd16843009;
      5'd9:    r = 33'd8405024;
      5'd10:   r = 33'd4198404;
      5'd11:   r = 33'd2098177;
      5'd12:   r = 33'd1048832;
      5'd13:   r = 33'd524352;
      5'd14:   r = 33'd262160;
      5'd15:   r = 33'd131076;
      5'd16:   r = 33'd65537;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/lvn_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvn_if
// Handshake channels of the layered value noise block.
// ----------------------------------------------------------------------------
interface lvn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] z_coord;
  modport source (output valid, x_coord, z_coord, input ready);
  modport sink   (input valid, x_coord, z_coord, output ready);
endinterface

interface lvn_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

interface lvn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/lvn_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvn_cell
// One octave: hash four lattice corners, smoothstep blend, fold into the sum.
// ----------------------------------------------------------------------------
module lvn_cell
  import lvn_pkg::*;
#(
  parameter int unsigned Oct = 0,
  parameter int unsigned AccW = 24,
  parameter int unsigned NW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [NW-1:0]   n_i,
  input  logic [31:0]     seed_i,
  input  lvn_ctl_t        ctl_i,
  input  logic [63:0]     bx_i,
  input  logic [63:0]     bz_i,
  input  logic [AccW-1:0] acc_i,
  output lvn_ctl_t        ctl_o,
  output logic [63:0]     bx_o,
  output logic [63:0]     bz_o,
  output logic [AccW-1:0] acc_o
);

  logic [3:0] vld_q;
  logic [63:0] bx_q [4];
  logic [63:0] bz_q [4];
  logic [AccW-1:0] acc_q [4];

  logic [63:0] px, pz;
  logic [31:0] ix, iz;

  // stage 1
  logic [31:0] mx0_q, mx1_q, mz0_q, mz1_q, ms_q, ttx_q, ttz_q;
  logic [15:0] tx_q, tz_q;
  // stage 2
  logic [31:0] g00_q, g10_q, g01_q, g11_q;
  logic [16:0] sx_q, sz_q;
  logic [17:0] wx, wz;
  logic [49:0] smx, smz;
  // stage 3
  logic [15:0] v0_q, v1_q;
  logic [16:0] sz3_q;
  // stage 4
  logic [15:0] v;

  assign px = bx_i << Oct;
  assign pz = bz_i << Oct;
  assign ix = px[63:32];
  assign iz = pz[63:32];
  assign wx = SmoothK - {1'b0, tx_q, 1'b0};
  assign wz = SmoothK - {1'b0, tz_q, 1'b0};
  assign smx = 50'(ttx_q) * 50'(wx);
  assign smz = 50'(ttz_q) * 50'(wz);
  assign v = lerp16(v0_q, v1_q, sz3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bx_q[0]  <= bx_i;
      bz_q[0]  <= bz_i;
      acc_q[0] <= acc_i;
      for (int k = 1; k < 4; k++) begin
        bx_q[k] <= bx_q[k-1];
        bz_q[k] <= bz_q[k-1];
      end
      acc_q[1] <= acc_q[0];
      acc_q[2] <= acc_q[1];
      if (32'(Oct) < 32'(n_i)) begin
        acc_q[3] <= {acc_q[2][AccW-2:0], 1'b0} + AccW'(v);
      end else begin
        acc_q[3] <= acc_q[2];
      end

      mx0_q <= 32'(ix * HashX);
      mx1_q <= 32'((ix + 32'd1) * HashX);
      mz0_q <= 32'(iz * HashZ);
      mz1_q <= 32'((iz + 32'd1) * HashZ);
      ms_q  <= 32'((seed_i + 32'(Oct)) * HashSeed);
      tx_q  <= px[31:16];
      tz_q  <= pz[31:16];
      ttx_q <= {16'b0, px[31:16]} * {16'b0, px[31:16]};
      ttz_q <= {16'b0, pz[31:16]} * {16'b0, pz[31:16]};

      g00_q <= hash_mix(mx0_q, mz0_q, ms_q);
      g10_q <= hash_mix(mx1_q, mz0_q, ms_q);
      g01_q <= hash_mix(mx0_q, mz1_q, ms_q);
      g11_q <= hash_mix(mx1_q, mz1_q, ms_q);
      sx_q  <= smx[48:32];
      sz_q  <= smz[48:32];

      v0_q  <= lerp16(hash_value(g00_q), hash_value(g10_q), sx_q);
      v1_q  <= lerp16(hash_value(g01_q), hash_value(g11_q), sx_q);
      sz3_q <= sz_q;
    end
  end

  assign ctl_o.valid = vld_q[3];
  assign bx_o  = bx_q[3];
  assign bz_o  = bz_q[3];
  assign acc_o = acc_q[3];

endmodule

// ----- rtl/lvn_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvn_norm
// Scales the octave sum by the amplitude reciprocal; holds the result word.
// ----------------------------------------------------------------------------
module lvn_norm
  import lvn_pkg::*;
#(
  parameter int unsigned AccW = 24,
  parameter int unsigned NW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [NW-1:0]   n_i,
  input  lvn_ctl_t        ctl_i,
  input  logic [AccW-1:0] acc_i,
  output lvn_ctl_t        ctl_o,
  output logic [16:0]     noise_o
);

  localparam int unsigned PW = AccW + 33;

  logic          vld_q, out_vld_q;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] rnd;
  logic [16:0]   noise_q;

  assign rnd = prod_q + PW'(33'h080000000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= ctl_i.valid;
      out_vld_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= PW'(acc_i) * PW'(recip(5'(n_i)));
      noise_q <= rnd[48:32];
    end
  end

  assign ctl_o.valid = out_vld_q;
  assign noise_o = noise_q;

endmodule

// ----- rtl/layered_value_noise_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_value_noise_top
// Multi-octave hashed 2D value noise over a chain of octave cells.
//
//   channel  dir  word
//   in_s     in   x_coord, z_coord (signed Q16.16)
//   out_m    out  noise_value (Q0.16, 0..65535)
//   cfg_s    in   index, data (octave count, base frequency, seed)
//
// One word per cycle unless the output stalls; path: scale, cells, norm.
// Every octave cell runs for every word; unused octaves pass the sum through.
// The whole pipe holds while the output word waits; no fill after reset.
// ----------------------------------------------------------------------------
module layered_value_noise_top
  import lvn_pkg::*;
#(
  parameter int unsigned MAX_OCTAVES = MaxOctavesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  lvn_in_if.sink    in_s,
  lvn_out_if.source out_m,
  lvn_cfg_if.sink   cfg_s
);

  localparam int unsigned AccW = 16 + MAX_OCTAVES;
  localparam int unsigned NW = $clog2(MAX_OCTAVES + 1);

  logic [3:0]  oct_q;
  logic [23:0] freq_q;
  logic [31:0] seed_q;
  logic [NW-1:0] n_eff;
  logic en;

  logic        vld0_q;
  logic [63:0] bx0_q, bz0_q;
  logic signed [56:0] mx, mz;

  lvn_ctl_t        ctl   [MAX_OCTAVES+1];
  logic [63:0]     bx    [MAX_OCTAVES+1];
  logic [63:0]     bz    [MAX_OCTAVES+1];
  logic [AccW-1:0] acc   [MAX_OCTAVES+1];
  lvn_ctl_t        out_ctl;

  always_comb begin
    if (oct_q == 4'd0) begin
      n_eff = NW'(1);
    end else if (32'(oct_q) > MAX_OCTAVES) begin
      n_eff = NW'(MAX_OCTAVES);
    end else begin
      n_eff = NW'(oct_q);
    end
  end

  assign en = !out_ctl.valid || out_m.ready;
  assign in_s.ready = en;
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q  <= OctavesReset;
      freq_q <= FreqReset;
      seed_q <= SeedReset;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        CFG_OCTAVES: oct_q  <= cfg_s.data[3:0];
        CFG_FREQ:    freq_q <= cfg_s.data[23:0];
        CFG_SEED:    seed_q <= cfg_s.data;
        default: ;
      endcase
    end
  end

  assign mx = in_s.x_coord * $signed({1'b0, freq_q});
  assign mz = in_s.z_coord * $signed({1'b0, freq_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bx0_q <= {{7{mx[56]}}, mx};
      bz0_q <= {{7{mz[56]}}, mz};
    end
  end

  assign ctl[0].valid = vld0_q;
  assign bx[0]  = bx0_q;
  assign bz[0]  = bz0_q;
  assign acc[0] = '0;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    lvn_cell #(
      .Oct  (g),
      .AccW (AccW),
      .NW   (NW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .n_i    (n_eff),
      .seed_i (seed_q),
      .ctl_i  (ctl[g]),
      .bx_i   (bx[g]),
      .bz_i   (bz[g]),
      .acc_i  (acc[g]),
      .ctl_o  (ctl[g+1]),
      .bx_o   (bx[g+1]),
      .bz_o   (bz[g+1]),
      .acc_o  (acc[g+1])
    );
  end

  lvn_norm #(
    .AccW (AccW),
    .NW   (NW)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .n_i     (n_eff),
    .ctl_i   (ctl[MAX_OCTAVES]),
    .acc_i   (acc[MAX_OCTAVES]),
    .ctl_o   (out_ctl),
    .noise_o (out_m.noise_value)
  );

  assign out_m.valid = out_ctl.valid;

endmodule

// ----- tb/lvn_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvn_checker
// Watches the input, output and register channels of the layered value noise
// block. It keeps its own copy of the registers, works out the noise value of
// every accepted sample point, and compares each output word with the oldest
// value still waiting.
// ----------------------------------------------------------------------------
module lvn_checker
  import lvn_pkg::*;
#(
  parameter int unsigned MAX_OCTAVES = MaxOctavesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  lvn_in_if    in_w,
  lvn_out_if   out_w,
  lvn_cfg_if   cfg_w,
  output int   errors_o,
  output int   pending_o
);

  logic [3:0]  octaves_q;
  logic [23:0] freq_q;
  logic [31:0] seed_q;
  logic [16:0] expected_noise[256];
  logic [7:0]  rd_ptr, wr_ptr;
  int          held;
  int          errors;

  function automatic logic [15:0] lattice_value(logic [31:0] ix, logic [31:0] iz,
                                                logic [31:0] sd);
    logic [31:0] h;
    h = ix * 32'd374761393 + iz * 32'd668265263 + sd * 32'd1274126177;
    h = (h ^ (h >> 13)) * 32'd1103515245;
    h = h ^ (h >> 16);
    return h[30:15];
  endfunction

  function automatic logic [63:0] ease(logic [15:0] t);
    logic [63:0] tt;
    tt = 64'(t);
    return (tt * tt * (64'd196608 - 2 * tt)) >> 32;
  endfunction

  function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * (64'd65536 - s) + b * s) >> 16;
  endfunction

  function automatic logic [16:0] noise_of(logic [31:0] x, logic [31:0] z);
    logic [63:0] bx, bz, px, pz, sx, sz, acc, d, r, v0, v1;
    logic [31:0] ix, iz, sd;
    int unsigned n;
    n = octaves_q;
    if (n < 1) n = 1;
    if (n > MAX_OCTAVES) n = MAX_OCTAVES;
    bx = {{32{x[31]}}, x} * {40'd0, freq_q};
    bz = {{32{z[31]}}, z} * {40'd0, freq_q};
    acc = 0;
    for (int i = 0; i < n; i++) begin
      px = bx << i;
      pz = bz << i;
      ix = px[63:32];
      iz = pz[63:32];
      sd = seed_q + 32'(i);
      sx = ease(px[31:16]);
      sz = ease(pz[31:16]);
      v0 = blend(64'(lattice_value(ix, iz, sd)), 64'(lattice_value(ix + 1, iz, sd)), sx);
      v1 = blend(64'(lattice_value(ix, iz + 1, sd)),
                 64'(lattice_value(ix + 1, iz + 1, sd)), sx);
      acc = (acc << 1) + blend(v0, v1, sz);
    end
    d = (64'd1 << n) - 1;
    r = ((64'd1 << 32) + (d >> 1)) / d;
    return 17'((acc * r + 64'h8000_0000) >> 32);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octaves_q = OctavesReset;
      freq_q    = FreqReset;
      seed_q    = SeedReset;
      rd_ptr    = '0;
      wr_ptr    = '0;
      held      = 0;
      errors    = 0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_w.index)
          CFG_OCTAVES: octaves_q = cfg_w.data[3:0];
          CFG_FREQ:    freq_q    = cfg_w.data[23:0];
          CFG_SEED:    seed_q    = cfg_w.data;
          default: ;
        endcase
      end
      if (out_w.valid && out_w.ready) begin
        if (held == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: noise_value=%0d", out_w.noise_value);
        end else begin
          logic [16:0] want;
          want = expected_noise[rd_ptr];
          rd_ptr = rd_ptr + 8'd1;
          held--;
          if (want !== out_w.noise_value) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: noise_value expected %0d actual %0d", want,
                       out_w.noise_value);
          end
        end
      end
      if (in_w.valid && in_w.ready) begin
        expected_noise[wr_ptr] = noise_of(in_w.x_coord, in_w.z_coord);
        wr_ptr = wr_ptr + 8'd1;
        held++;
      end
    end
    errors_o  = errors;
    pending_o = held;
  end

endmodule

// ----- tb/tb_layered_value_noise_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_layered_value_noise_top
// Regression of the layered value noise block: directed corner points and
// register extremes, then phases of random sample points under random
// register settings, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_layered_value_noise_top;
  import lvn_pkg::*;

  localparam int Latency = 3 + 4 * MaxOctavesDefault;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   errors, pending;
  int   cycles = 0;
  bit   no_idle;
  bit   stall_req = 1'b0;

  lvn_in_if  in_s();
  lvn_out_if out_m();
  lvn_cfg_if cfg_s();

  layered_value_noise_top uut (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_s(in_s), .out_m(out_m), .cfg_s(cfg_s)
  );

  lvn_checker chk (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_w(in_s), .out_w(out_m), .cfg_w(cfg_s),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("layered_value_noise_top regression: fail");
      $finish;
    end
  end

  task automatic idle_gap(output int gap);
    gap = no_idle ? 0 : $urandom_range(3, 0);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] z);
    int gap;
    idle_gap(gap);
    if (gap > 0) begin
      in_s.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_s.valid   <= 1'b1;
    in_s.x_coord <= x;
    in_s.z_coord <= z;
    @(posedge clk_i);
    while (!in_s.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_s.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_s.valid <= 1'b1;
    cfg_s.index <= idx;
    cfg_s.data  <= value;
    @(posedge clk_i);
    while (!cfg_s.ready) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] oct, logic [31:0] freq, logic [31:0] seed);
    drain();
    write_reg(CFG_OCTAVES, oct);
    write_reg(CFG_FREQ, freq);
    write_reg(CFG_SEED, seed);
    cfg_s.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3, 0))
      0, 1:    return $urandom();
      2:       return 32'($signed($urandom_range(2000000, 0)) - 1000000);
      default: return {$urandom_range(1, 0) ? 16'hFFFF : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  // receiver
  initial begin
    int gap;
    bit stall_done;
    stall_done = 1'b0;
    out_m.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (stall_req && !stall_done) begin
        out_m.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        stall_done = 1'b1;
      end
      idle_gap(gap);
      if (gap > 0) begin
        out_m.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_m.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_m.valid) @(posedge clk_i);
    end
  end

  initial begin
    logic [31:0] corners[8];
    logic [31:0] oct, freq, seed;
    corners = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                32'h0000_0001, 32'h0000_8000, 32'h0000_FFFF, 32'h0001_0000};
    no_idle      = 1'b0;
    rst_ni       <= 1'b0;
    in_s.valid   <= 1'b0;
    in_s.x_coord <= '0;
    in_s.z_coord <= '0;
    cfg_s.valid  <= 1'b0;
    cfg_s.index  <= CFG_OCTAVES;
    cfg_s.data   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < 8; k++) send_point(corners[k], corners[7 - k]);
    // zero and oversized octave counts, zero and full frequency
    set_regs(0, 0, 32'hFFFF_FFFF);
    send_point(32'h1234_5678, 32'h8765_4321);
    set_regs(15, 24'hFF_FFFF, 0);
    for (int k = 0; k < 4; k++) send_point(corners[k], corners[k + 4]);
    set_regs(1, 1, 32'h5555_5555);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    set_regs(8, 24'hFF_FFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < 4; k++) send_point(corners[k + 1], corners[k]);
    set_regs(9, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_point(32'hFFFF_FFFF, 32'h0000_0001);

    for (int ph = 0; ph < 8; ph++) begin
      oct  = (ph < 2) ? (ph == 0 ? 1 : 8) : $urandom_range(15, 0);
      case ($urandom_range(3, 0))
        0:       freq = $urandom_range(1, 0) ? 24'hFF_FFFF : 1;
        1:       freq = $urandom_range(24'h04_0000, 24'h00_4000);
        default: freq = $urandom();
      endcase
      seed = $urandom();
      set_regs(oct, freq, seed);
      no_idle = (ph == 3);
      for (int k = 0; k < 250; k++) begin
        if (ph == 5 && k == 20) stall_req = 1'b1;
        send_point(rand_coord(), rand_coord());
      end
    end
    no_idle = 1'b0;
    drain();
    if (errors == 0) begin
      $display("layered_value_noise_top regression: pass");
    end else begin
      $display("layered_value_noise_top regression: fail");
    end
    $finish;
  end

endmodule
